// ===== design/ogp_pkg.sv =====
package ogp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int SLOT_COUNT   = MAX_WIDTH / 2;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;
  localparam int CFG_DATA_W   = 13;
  localparam int CELL_W       = 8;
  localparam int POOL_W       = 7;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = WIDTH_REG_W'(2);
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_LIMIT  = WIDTH_REG_W'(MAX_WIDTH);
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(200);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = HEIGHT_REG_W'(2);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = HEIGHT_REG_W'(4096);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(400);
  localparam logic [POOL_W-1:0]       OCCUPIED_VALUE = POOL_W'(100);
  localparam logic [POOL_W-1:0]       FREE_VALUE     = POOL_W'(0);

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              data;
  } line_wr_t;

endpackage

// ===== design/occupancy_grid_pool_2x2_unit.sv =====
// 2x2 binary pooling of an occupancy grid stream.
// Input channel (in_valid / in_ready): one signed cell per item, raster order.
// Output channel (out_valid / out_ready): one pooled item per 2x2 block,
// 100 if any cell of the block is nonzero, else 0; frame_last marks the
// final block of the frame.
// Configuration: cfg_write with cfg_index 0 sets grid_width, 1 sets
// grid_height; odd sizes are rounded down to even and the trailing column
// or row is consumed without output. Write only while the block is idle.
// Throughput: one item per cycle while in_ready is high; every item does
// at most one write and one read of the single-bit line store (one entry
// per pair of columns). The pooled item is valid the cycle after the second
// cell of the block's odd-row pair is accepted.
// Stall: the output register holds its item; in_ready stays high while the
// output register is empty or being taken, and drops otherwise.
// Reset: counters cleared, grid_width 200, grid_height 400, output empty.
// The line store is not cleared; every entry is written by an even row
// before the following odd row reads it.
module occupancy_grid_pool_2x2_unit
  import ogp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CELL_W-1:0] cell_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POOL_W-1:0]       pooled_value,
  output logic                    frame_last
);

  logic [WIDTH_REG_W-1:0]  grid_width;
  logic [HEIGHT_REG_W-1:0] grid_height;
  logic [COL_W-1:0]        column_count;
  logic [COL_W-1:0]        column_count_next;
  logic [ROW_W-1:0]        row_count;
  logic [ROW_W-1:0]        row_count_next;
  logic                    pair_occupied;

  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [WIDTH_REG_W-1:0]  used_w;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [HEIGHT_REG_W-1:0] used_h;
  logic [WIDTH_REG_W-1:0]  col_ext;
  logic [WIDTH_REG_W-1:0]  col_inc;
  logic [HEIGHT_REG_W-1:0] row_ext;
  logic [HEIGHT_REG_W-1:0] row_inc;
  logic                    accept;
  logic                    in_grid;
  logic                    occ;
  logic                    pair;
  logic                    produce;
  logic                    last_block;
  line_wr_t                wr;
  logic [SLOT_W-1:0]       rd_addr;
  logic                    line_bit;

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (grid_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (grid_width > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (grid_height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = grid_height;
    end
    used_w = {w_eff[WIDTH_REG_W-1:1], 1'b0};
    used_h = {h_eff[HEIGHT_REG_W-1:1], 1'b0};

    col_ext = WIDTH_REG_W'(column_count);
    col_inc = col_ext + WIDTH_REG_W'(1);
    row_ext = HEIGHT_REG_W'(row_count);
    row_inc = row_ext + HEIGHT_REG_W'(1);

    in_grid    = (col_ext < used_w) && (row_ext < used_h);
    occ        = (cell_value != '0);
    pair       = pair_occupied || occ;
    produce    = in_grid && column_count[0] && row_count[0];
    last_block = (row_ext == used_h - HEIGHT_REG_W'(1))
              && (col_ext == used_w - WIDTH_REG_W'(1));

    wr.en   = accept && in_grid && column_count[0] && !row_count[0];
    wr.addr = column_count[COL_W-1:1];
    wr.data = pair;

    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next = (row_ext >= h_eff) ? '0 : row_count;
    end

    // address of the pair the next item falls into
    rd_addr = accept ? column_count_next[COL_W-1:1] : column_count[COL_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_RESET;
      grid_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      pair_occupied <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (in_grid && !column_count[0]) begin
        pair_occupied <= occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      pooled_value <= (line_bit || pair) ? OCCUPIED_VALUE : FREE_VALUE;
      frame_last   <= last_block;
    end
  end

  ogp_line_store u_line_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (line_bit)
  );

  a_pool_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pooled_value == OCCUPIED_VALUE) || (pooled_value == FREE_VALUE))
    else $error("pooled item holds an illegal value");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) |=> out_valid)
    else $error("block result lost");

  a_forward: assert property (@(posedge clk) disable iff (rst)
    (wr.en && (wr.addr == rd_addr)) |=> (line_bit == $past(wr.data)))
    else $error("line store forwarding failed");

  a_result_parity: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) |-> (column_count[0] && row_count[0] && !wr.en))
    else $error("result on an even cell or row");

endmodule

// ===== design/ogp_line_store.sv =====
module ogp_line_store
  import ogp_pkg::*;
(
  input  logic              clk,
  input  line_wr_t          wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read every cycle, new data forwarded on a same-entry write
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
